FILE: rtl/core/hrpg_pkg.sv
`default_nettype none

package hrpg_pkg;

    localparam int DEF_BACKGROUND_INTERVAL = 64;
    localparam int DEF_TOGGLE_INTERVAL     = 4;

    localparam int OP_W        = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int RUN_TIME_W  = 24;

    localparam logic [7:0] INVALID_BYTE   = 8'hFF;
    localparam logic [6:0] PAGE_PREV_BEAT = 7'd4;

    typedef enum logic [OP_W-1:0] {
        OP_BEAT     = 3'd0,
        OP_RATE     = 3'd1,
        OP_RUN_TIME = 3'd2,
        OP_DATA     = 3'd3,
        OP_OTHER    = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MANUFACTURER = 3'd0,
        CFG_SERIAL_HIGH  = 3'd1,
        CFG_HW_VERSION   = 3'd2,
        CFG_SW_VERSION   = 3'd3,
        CFG_MODEL        = 3'd4
    } cfg_reg_t;

    // background rotation, in transmit order
    typedef enum logic [1:0] {
        BG_DEFAULT      = 2'd0,
        BG_CUM_TIME     = 2'd1,
        BG_MANUFACTURER = 2'd2,
        BG_PRODUCT      = 2'd3
    } bg_page_t;

    typedef struct packed {
        logic [7:0]  manufacturer_id;
        logic [15:0] serial_high;
        logic [7:0]  hardware_version;
        logic [7:0]  software_version;
        logic [7:0]  model_number;
    } config_t;

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        logic [15:0]     beat_time;
        logic [7:0]      bpm;
        logic [31:0]     seconds;
    } item_t;

    typedef struct packed {
        logic [7:0] page_byte;
        logic [7:0] body_byte1;
        logic [7:0] body_byte2;
        logic [7:0] body_byte3;
        logic [7:0] event_time_low;
        logic [7:0] event_time_high;
        logic [7:0] beat_count_byte;
        logic [7:0] heart_rate_byte;
    } page_t;

endpackage

`default_nettype wire

FILE: rtl/core/hrpg_cfg_regs.sv
`default_nettype none

module hrpg_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [hrpg_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [hrpg_pkg::CFG_DATA_W-1:0]  wr_data,
    output hrpg_pkg::config_t                     cfg
);
    import hrpg_pkg::*;

    config_t cfg_reg;
    config_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_MANUFACTURER: cfg_next.manufacturer_id  = wr_data[7:0];
                CFG_SERIAL_HIGH:  cfg_next.serial_high      = wr_data;
                CFG_HW_VERSION:   cfg_next.hardware_version = wr_data[7:0];
                CFG_SW_VERSION:   cfg_next.software_version = wr_data[7:0];
                CFG_MODEL:        cfg_next.model_number     = wr_data[7:0];
                default:          cfg_next = cfg_reg;   // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hrpg_in_stage.sv
`default_nettype none

module hrpg_in_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [hrpg_pkg::OP_W-1:0] op,
    input  wire logic [15:0]               beat_time,
    input  wire logic [7:0]                bpm,
    input  wire logic [31:0]               seconds,
    input  wire logic                      take,
    output hrpg_pkg::item_t                item
);
    import hrpg_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [OP_W-1:0] op_reg;
    logic [15:0]     beat_time_reg;
    logic [7:0]      bpm_reg;
    logic [31:0]     seconds_reg;
    logic            accept;

    // held item leaves this cycle or the stage is empty
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op;
            beat_time_reg <= beat_time;
            bpm_reg       <= bpm;
            seconds_reg   <= seconds;
        end
    end

    assign item.valid     = valid_reg;
    assign item.op        = op_reg;
    assign item.beat_time = beat_time_reg;
    assign item.bpm       = bpm_reg;
    assign item.seconds   = seconds_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hrpg_core.sv
`default_nettype none

module hrpg_core #(
    parameter int BACKGROUND_INTERVAL = hrpg_pkg::DEF_BACKGROUND_INTERVAL,
    parameter int TOGGLE_INTERVAL     = hrpg_pkg::DEF_TOGGLE_INTERVAL
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hrpg_pkg::item_t   item,
    input  wire hrpg_pkg::config_t cfg,
    output logic                   take,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output hrpg_pkg::page_t        page
);
    import hrpg_pkg::*;

    localparam int SLOT_W = (BACKGROUND_INTERVAL > 1) ? $clog2(BACKGROUND_INTERVAL) : 1;
    localparam int MSG_W  = $clog2(2 * TOGGLE_INTERVAL);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BACKGROUND_INTERVAL - 1);
    localparam logic [MSG_W-1:0]  MSG_LAST  = MSG_W'(2 * TOGGLE_INTERVAL - 1);
    localparam logic [MSG_W-1:0]  TOGGLE_AT = MSG_W'(TOGGLE_INTERVAL);

    logic [15:0]           last_beat_reg,  last_beat_next;
    logic [15:0]           prior_beat_reg, prior_beat_next;
    logic [7:0]            beat_total_reg, beat_total_next;
    logic [7:0]            rate_reg,       rate_next;
    logic [RUN_TIME_W-1:0] run_time_reg,   run_time_next;
    logic [SLOT_W-1:0]     slot_reg,       slot_next;
    bg_page_t              bg_reg,         bg_next;
    logic [MSG_W-1:0]      msg_reg,        msg_next;
    logic                  out_valid_reg,  out_valid_next;
    page_t                 page_reg,       page_next;

    logic out_free;
    logic is_data;
    logic bump_msg;
    logic toggle;
    logic background;

    assign out_free = !out_valid_reg || !out_stall;
    assign is_data  = (item.op == OP_DATA);
    // only a data slot needs room in the result register
    assign take     = item.valid && (!is_data || out_free);
    assign toggle   = (msg_reg >= TOGGLE_AT);
    assign background = (slot_reg == SLOT_LAST);

    always_comb
    begin
        last_beat_next  = last_beat_reg;
        prior_beat_next = prior_beat_reg;
        beat_total_next = beat_total_reg;
        rate_next       = rate_reg;
        run_time_next   = run_time_reg;
        slot_next       = slot_reg;
        bg_next         = bg_reg;
        bump_msg        = 1'b0;
        if (take)
        begin
            unique case (item.op)
                OP_BEAT:
                begin
                    prior_beat_next = last_beat_reg;
                    last_beat_next  = item.beat_time;
                    beat_total_next = beat_total_reg + 8'd1;
                end
                OP_RATE:     rate_next     = item.bpm;
                OP_RUN_TIME: run_time_next = item.seconds[RUN_TIME_W:1];
                OP_DATA:
                begin
                    slot_next = background ? '0 : slot_reg + 1'b1;
                    if (background)
                        bg_next = bg_page_t'(bg_reg + 2'd1);
                    bump_msg = 1'b1;
                end
                OP_OTHER:    bump_msg = 1'b1;
                default:     bump_msg = 1'b0;   // unused codes change nothing
            endcase
        end
        msg_next = msg_reg;
        if (bump_msg)
            msg_next = (msg_reg == MSG_LAST) ? '0 : msg_reg + 1'b1;
    end

    always_comb
    begin
        page_next                 = page_reg;
        page_next.event_time_low  = last_beat_reg[7:0];
        page_next.event_time_high = last_beat_reg[15:8];
        page_next.beat_count_byte = beat_total_reg;
        page_next.heart_rate_byte = rate_reg;
        if (background)
        begin
            page_next.page_byte = {toggle, 5'b0, bg_reg};
            unique case (bg_reg)
                BG_DEFAULT:
                begin
                    page_next.body_byte1 = INVALID_BYTE;
                    page_next.body_byte2 = INVALID_BYTE;
                    page_next.body_byte3 = INVALID_BYTE;
                end
                BG_CUM_TIME:
                begin
                    page_next.body_byte1 = run_time_reg[7:0];
                    page_next.body_byte2 = run_time_reg[15:8];
                    page_next.body_byte3 = run_time_reg[23:16];
                end
                BG_MANUFACTURER:
                begin
                    page_next.body_byte1 = cfg.manufacturer_id;
                    page_next.body_byte2 = cfg.serial_high[7:0];
                    page_next.body_byte3 = cfg.serial_high[15:8];
                end
                BG_PRODUCT:
                begin
                    page_next.body_byte1 = cfg.hardware_version;
                    page_next.body_byte2 = cfg.software_version;
                    page_next.body_byte3 = cfg.model_number;
                end
                default:
                begin
                    page_next.body_byte1 = INVALID_BYTE;
                    page_next.body_byte2 = INVALID_BYTE;
                    page_next.body_byte3 = INVALID_BYTE;
                end
            endcase
        end
        else
        begin
            page_next.page_byte  = {toggle, PAGE_PREV_BEAT};
            page_next.body_byte1 = INVALID_BYTE;
            page_next.body_byte2 = prior_beat_reg[7:0];
            page_next.body_byte3 = prior_beat_reg[15:8];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && is_data)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_beat_reg  <= '0;
            prior_beat_reg <= '0;
            beat_total_reg <= '0;
            rate_reg       <= '0;
            run_time_reg   <= '0;
            slot_reg       <= '0;
            bg_reg         <= BG_DEFAULT;
            msg_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_beat_reg  <= last_beat_next;
            prior_beat_reg <= prior_beat_next;
            beat_total_reg <= beat_total_next;
            rate_reg       <= rate_next;
            run_time_reg   <= run_time_next;
            slot_reg       <= slot_next;
            bg_reg         <= bg_next;
            msg_reg        <= msg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_data)
            page_reg <= page_next;
    end

    assign out_valid = out_valid_reg;
    assign page      = page_reg;

    // a data slot off the background phase must carry the previous-beat page
    a_prev_beat_page: assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_data && !background) |=> (page_reg.page_byte[6:0] == PAGE_PREV_BEAT))
        else $error("previous-beat page expected");

    a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.op == OP_BEAT) |=> (beat_total_reg == 8'($past(beat_total_reg) + 8'd1)))
        else $error("beat count did not advance");

    // a result only appears for a data slot
    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(take && is_data)) |=> !out_valid_reg)
        else $error("result raised without a data slot");

    a_rotation_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_data && background) |=> (bg_reg == bg_page_t'($past(bg_reg) + 2'd1)))
        else $error("background rotation did not advance");

endmodule

`default_nettype wire

FILE: rtl/core/heart_rate_page_generator.sv
// Heart-rate sensor page builder.
// Input channel (in_valid/in_stall, fields op, beat_time, bpm, seconds) carries
// events: heartbeat, rate update, operating-time update, data slot, other message.
// Only a data slot produces a result: one 8-byte page on the output channel
// (out_valid/out_stall). Other events update internal state and give nothing.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; write them only while the block is idle.
// A data slot passes the input register, then the result register, where its
// page is presented on the output channel. Throughput is one event per cycle
// while the input stage does not stall; the state update and page selection
// fit between the two registers.
// While the receiver stalls, the held page stays put; the input stage keeps
// taking non-page events and stalls only when a data slot finds the result
// register still occupied.
// Reset clears all counters, stored times, rate, run time and config to zero;
// the first background page after reset is the default page.
`default_nettype none

module heart_rate_page_generator #(
    parameter int BACKGROUND_INTERVAL = hrpg_pkg::DEF_BACKGROUND_INTERVAL,
    parameter int TOGGLE_INTERVAL     = hrpg_pkg::DEF_TOGGLE_INTERVAL
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [hrpg_pkg::OP_W-1:0]        op,
    input  wire logic [15:0]                      beat_time,
    input  wire logic [7:0]                       bpm,
    input  wire logic [31:0]                      seconds,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            page_byte,
    output logic [7:0]                            body_byte1,
    output logic [7:0]                            body_byte2,
    output logic [7:0]                            body_byte3,
    output logic [7:0]                            event_time_low,
    output logic [7:0]                            event_time_high,
    output logic [7:0]                            beat_count_byte,
    output logic [7:0]                            heart_rate_byte,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hrpg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hrpg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hrpg_pkg::*;

    config_t cfg;
    item_t   item;
    page_t   page;
    logic    take;

    assign cfg_ready = 1'b1;

    hrpg_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hrpg_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .beat_time (beat_time),
        .bpm       (bpm),
        .seconds   (seconds),
        .take      (take),
        .item      (item)
    );

    hrpg_core #(
        .BACKGROUND_INTERVAL (BACKGROUND_INTERVAL),
        .TOGGLE_INTERVAL     (TOGGLE_INTERVAL)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .page      (page)
    );

    assign page_byte       = page.page_byte;
    assign body_byte1      = page.body_byte1;
    assign body_byte2      = page.body_byte2;
    assign body_byte3      = page.body_byte3;
    assign event_time_low  = page.event_time_low;
    assign event_time_high = page.event_time_high;
    assign beat_count_byte = page.beat_count_byte;
    assign heart_rate_byte = page.heart_rate_byte;

endmodule

`default_nettype wire

FILE: verif/hrpg_page_checker.sv
module hrpg_page_checker #(
    parameter int BACKGROUND_INTERVAL = hrpg_pkg::DEF_BACKGROUND_INTERVAL,
    parameter int TOGGLE_INTERVAL     = hrpg_pkg::DEF_TOGGLE_INTERVAL
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [hrpg_pkg::OP_W-1:0]        op,
    input  wire logic [15:0]                      beat_time,
    input  wire logic [7:0]                       bpm,
    input  wire logic [31:0]                      seconds,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [7:0]                       page_byte,
    input  wire logic [7:0]                       body_byte1,
    input  wire logic [7:0]                       body_byte2,
    input  wire logic [7:0]                       body_byte3,
    input  wire logic [7:0]                       event_time_low,
    input  wire logic [7:0]                       event_time_high,
    input  wire logic [7:0]                       beat_count_byte,
    input  wire logic [7:0]                       heart_rate_byte,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [hrpg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hrpg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                    mismatch_count,
    output int                                    pages_waiting,
    output int                                    pages_checked,
    output int                                    background_pages
);
    import hrpg_pkg::*;

    // predicted sensor state
    logic [15:0]           last_beat;
    logic [15:0]           prior_beat;
    logic [7:0]            beat_count;
    logic [7:0]            heart_rate;
    logic [RUN_TIME_W-1:0] run_units;
    int unsigned           slot_count;
    int unsigned           msg_count;
    logic [1:0]            next_background;
    config_t               regs;

    page_t expected_pages[$];
    page_t want;
    page_t got;
    string field_names [0:7] = '{"page_byte", "body_byte1", "body_byte2", "body_byte3",
                                 "event_time_low", "event_time_high",
                                 "beat_count_byte", "heart_rate_byte"};

    task automatic take_event(input logic [OP_W-1:0] ev_op, input logic [15:0] ev_time,
                              input logic [7:0] ev_bpm, input logic [31:0] ev_secs);
        page_t pg;
        logic  toggle;
        pg = '0;
        case (ev_op)
            OP_BEAT:
            begin
                prior_beat = last_beat;
                last_beat  = ev_time;
                beat_count = beat_count + 8'd1;
            end
            OP_RATE:     heart_rate = ev_bpm;
            // two-second units, kept to 24 bits
            OP_RUN_TIME: run_units = ev_secs[RUN_TIME_W:1];
            OP_OTHER:    msg_count = (msg_count + 1) % (2 * TOGGLE_INTERVAL);
            OP_DATA:
            begin
                toggle     = ((msg_count / TOGGLE_INTERVAL) % 2) == 1;
                slot_count = (slot_count + 1) % BACKGROUND_INTERVAL;
                if (slot_count != 0)
                begin
                    pg.page_byte  = {toggle, PAGE_PREV_BEAT};
                    pg.body_byte1 = INVALID_BYTE;
                    {pg.body_byte3, pg.body_byte2} = prior_beat;
                end
                else
                begin
                    pg.page_byte = {toggle, 5'b00000, next_background};
                    case (next_background)
                        BG_DEFAULT:
                        begin
                            pg.body_byte1 = INVALID_BYTE;
                            pg.body_byte2 = INVALID_BYTE;
                            pg.body_byte3 = INVALID_BYTE;
                        end
                        BG_CUM_TIME:
                            {pg.body_byte3, pg.body_byte2, pg.body_byte1} = run_units;
                        BG_MANUFACTURER:
                        begin
                            pg.body_byte1 = regs.manufacturer_id;
                            {pg.body_byte3, pg.body_byte2} = regs.serial_high;
                        end
                        default:
                        begin
                            pg.body_byte1 = regs.hardware_version;
                            pg.body_byte2 = regs.software_version;
                            pg.body_byte3 = regs.model_number;
                        end
                    endcase
                    next_background  = next_background + 2'd1;
                    background_pages = background_pages + 1;
                end
                {pg.event_time_high, pg.event_time_low} = last_beat;
                pg.beat_count_byte = beat_count;
                pg.heart_rate_byte = heart_rate;
                expected_pages.push_back(pg);
                msg_count = (msg_count + 1) % (2 * TOGGLE_INTERVAL);
            end
            default: ;  // spare op codes leave everything untouched
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_beat        = '0;
            prior_beat       = '0;
            beat_count       = '0;
            heart_rate       = '0;
            run_units        = '0;
            slot_count       = 0;
            msg_count        = 0;
            next_background  = '0;
            regs             = '0;
            expected_pages.delete();
            pages_waiting    = 0;
            mismatch_count   = 0;
            pages_checked    = 0;
            background_pages = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MANUFACTURER: regs.manufacturer_id  = cfg_data[7:0];
                    CFG_SERIAL_HIGH:  regs.serial_high      = cfg_data;
                    CFG_HW_VERSION:   regs.hardware_version = cfg_data[7:0];
                    CFG_SW_VERSION:   regs.software_version = cfg_data[7:0];
                    CFG_MODEL:        regs.model_number     = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                got = {page_byte, body_byte1, body_byte2, body_byte3,
                       event_time_low, event_time_high, beat_count_byte, heart_rate_byte};
                if (expected_pages.size() == 0)
                begin
                    $error("page transfer with nothing expected: %016h", got);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = expected_pages.pop_front();
                    for (int k = 0; k < 8; k++)
                    begin
                        if (got[63-8*k -: 8] !== want[63-8*k -: 8])
                        begin
                            $error("%s: expected %02h, got %02h", field_names[k],
                                   want[63-8*k -: 8], got[63-8*k -: 8]);
                            mismatch_count = mismatch_count + 1;
                        end
                    end
                    pages_checked = pages_checked + 1;
                end
            end

            if (in_valid && !in_stall)
                take_event(op, beat_time, bpm, seconds);

            pages_waiting = expected_pages.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import hrpg_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 6;     // two register stages plus margin
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASES       = 4;
    localparam int TIMEOUT      = 2_000_000;

    localparam logic [OP_W-1:0]        OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0]        OP_SPARE_LAST  = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED   = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [OP_W-1:0]        op;
    logic [15:0]            beat_time;
    logic [7:0]             bpm;
    logic [31:0]            seconds;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             page_byte;
    logic [7:0]             body_byte1;
    logic [7:0]             body_byte2;
    logic [7:0]             body_byte3;
    logic [7:0]             event_time_low;
    logic [7:0]             event_time_high;
    logic [7:0]             beat_count_byte;
    logic [7:0]             heart_rate_byte;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatch_count;
    int pages_waiting;
    int pages_checked;
    int background_pages;
    int events_sent;
    int reg_writes;
    bit hold_request;

    heart_rate_page_generator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .beat_time(beat_time), .bpm(bpm), .seconds(seconds),
        .out_valid(out_valid), .out_stall(out_stall),
        .page_byte(page_byte), .body_byte1(body_byte1), .body_byte2(body_byte2),
        .body_byte3(body_byte3), .event_time_low(event_time_low),
        .event_time_high(event_time_high), .beat_count_byte(beat_count_byte),
        .heart_rate_byte(heart_rate_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hrpg_page_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .beat_time(beat_time), .bpm(bpm), .seconds(seconds),
        .out_valid(out_valid), .out_stall(out_stall),
        .page_byte(page_byte), .body_byte1(body_byte1), .body_byte2(body_byte2),
        .body_byte3(body_byte3), .event_time_low(event_time_low),
        .event_time_high(event_time_high), .beat_count_byte(beat_count_byte),
        .heart_rate_byte(heart_rate_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatch_count(mismatch_count), .pages_waiting(pages_waiting),
        .pages_checked(pages_checked), .background_pages(background_pages)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_event(input logic [OP_W-1:0] ev_op, input logic [15:0] ev_time,
                              input logic [7:0] ev_bpm, input logic [31:0] ev_secs);
        @(negedge clk);
        in_valid  <= 1'b1;
        op        <= ev_op;
        beat_time <= ev_time;
        bpm       <= ev_bpm;
        seconds   <= ev_secs;
        do
            @(posedge clk);
        while (in_stall);
        if (ev_op <= OP_OTHER)
            events_sent = events_sent + 1;
    endtask

    task automatic send_random_event();
        int               pick;
        logic [OP_W-1:0]  ev_op;
        logic [15:0]      ev_time;
        logic [7:0]       ev_bpm;
        pick    = $urandom_range(0, 99);
        ev_time = 16'($urandom);
        ev_bpm  = 8'($urandom);
        if (pick < 48)
            ev_op = OP_DATA;
        else if (pick < 66)
            ev_op = OP_BEAT;
        else if (pick < 76)
            ev_op = OP_RATE;
        else if (pick < 83)
            ev_op = OP_RUN_TIME;
        else if (pick < 96)
            ev_op = OP_OTHER;
        else
            ev_op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        send_event(ev_op, ev_time, ev_bpm, $urandom);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // stop offering, let every page arrive, then allow for anything still in flight
    task automatic wait_drained();
        idle_sender(1);
        while (pages_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid  <= 1'b0;
        reg_writes = reg_writes + 1;
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] mfr, input logic [CFG_DATA_W-1:0] serial,
                                 input logic [CFG_DATA_W-1:0] hw, input logic [CFG_DATA_W-1:0] sw,
                                 input logic [CFG_DATA_W-1:0] model);
        wait_drained();
        write_reg(CFG_MANUFACTURER, mfr);
        write_reg(CFG_SERIAL_HIGH, serial);
        write_reg(CFG_HW_VERSION, hw);
        write_reg(CFG_SW_VERSION, sw);
        write_reg(CFG_MODEL, model);
    endtask

    // receiver: phases of differing stall density, plus an occasional long hold-off
    initial
    begin : receiver
        int hold_left;
        int phase_left;
        int stall_pct;
        hold_left  = 0;
        phase_left = 0;
        stall_pct  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(10, 200);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            phase_left = phase_left - 1;
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(1, 100) <= stall_pct);
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("timed out with %0d pages outstanding", pages_waiting);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int burst_len;
        int target;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_BEAT;
        beat_time    = '0;
        bpm          = '0;
        seconds      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_MANUFACTURER;
        cfg_data     = '0;
        events_sent  = 0;
        reg_writes   = 0;
        hold_request = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // first page straight out of reset, before any register is touched
        send_event(OP_DATA, '0, '0, '0);
        load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));

        send_event(OP_BEAT, 16'hFFFF, '0, '0);
        send_event(OP_BEAT, 16'h0000, '0, '0);
        send_event(OP_DATA, '0, '0, '0);
        send_event(OP_BEAT, 16'h8001, '0, '0);
        send_event(OP_RATE, '0, 8'hFF, '0);
        send_event(OP_RUN_TIME, '0, '0, 32'hFFFF_FFFF);
        send_event(OP_DATA, '0, '0, '0);
        send_event(OP_RATE, '0, 8'h00, '0);
        send_event(OP_RUN_TIME, '0, '0, 32'h0000_0001);
        // spare op codes must change nothing
        for (int u = OP_SPARE_FIRST; u <= OP_SPARE_LAST; u++)
            send_event(OP_W'(u), 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_event(OP_DATA, '0, '0, '0);
        send_event(OP_OTHER, '0, '0, '0);
        send_event(OP_OTHER, '0, '0, '0);
        send_event(OP_DATA, '0, '0, '0);
        // two-second units overflow past 24 bits
        send_event(OP_RUN_TIME, '0, '0, 32'h0200_0003);
        send_event(OP_OTHER, '0, '0, '0);
        send_event(OP_DATA, '0, '0, '0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: load_settings('1, '1, '1, '1, '1);
                1:
                begin
                    load_settings('0, '0, '0, '0, '0);
                    write_reg(CFG_UNMAPPED, '1);
                end
                default:
                    load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                  CFG_DATA_W'($urandom));
            endcase

            if (phase == 1)
            begin
                // receiver holds off while data slots keep coming, so the input backs up
                hold_request = 1'b1;
                repeat (40) send_event(OP_DATA, 16'($urandom), 8'($urandom), $urandom);
            end

            target = events_sent + RANDOM_ITEMS / PHASES;
            while (events_sent < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    burst_len = $urandom_range(60, 150);
                else
                    burst_len = $urandom_range(1, 20);
                repeat (burst_len) send_random_event();
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 12));
            end
        end

        wait_drained();
        $display("%0d events, %0d pages checked (%0d background), %0d register writes",
                 events_sent, pages_checked, background_pages, reg_writes);
        $display("settings covered: reset, random, all ones, all zeros; with long receiver hold");
        if (mismatch_count == 0 && pages_waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
